// ===== sv/it2fpi_pkg.sv =====
// ----------------------------------------------------------------------------
// it2fpi_pkg
// Shared types, constants and the microprogram of the interval type-2 fuzzy
// PI axis core.
// ----------------------------------------------------------------------------
package it2fpi_pkg;

  localparam int PC_W = 7;

  localparam logic signed [63:0] ONE24  = 64'sd16777216;
  localparam logic [63:0]        PI_Q32 = 64'd13493037705;
  localparam logic [1:0]         YAW_AXIS = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_INPUT_GAIN      = 3'd0;
  localparam logic [2:0] REG_DERIV_INPUT_GAIN     = 3'd1;
  localparam logic [2:0] REG_PROP_OUTPUT_GAIN     = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_OUTPUT_GAIN = 3'd3;
  localparam logic [2:0] REG_LOWER_HEIGHT_FIRST   = 3'd4;
  localparam logic [2:0] REG_LOWER_HEIGHT_SECOND  = 3'd5;
  localparam logic [2:0] REG_STEP_TIME            = 3'd6;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLIP, OP_BELOW, OP_BR, OP_ACC, OP_DONE
  } op_t;

  typedef enum logic [4:0] {
    R_ZERO, R_ONE, R_UNIT, R_KP, R_KD, R_KPO, R_KIO, R_DT,
    R_E1, R_E2, R_A, R_B, R_S1, R_S2, R_N12, R_D12, R_N23, R_D23,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7, R_PHI, R_INTEG
  } reg_id_t;

  typedef enum logic [2:0] {SH_0, SH_24, SH_F, SH_48F, SH_24F} sh_t;

  typedef enum logic [1:0] {C_ALWAYS, C_POS, C_NFLAG} cond_t;

  typedef struct packed {
    op_t             op;
    reg_id_t         dst;
    reg_id_t         a;
    reg_id_t         b;
    sh_t             sh;
    logic            clamp;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uop_t;

  typedef struct packed {
    logic load;
    logic run;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic take;
  } dp_stat_t;

  // branch targets
  localparam logic [PC_W-1:0] L_POS   = 7'd11;
  localparam logic [PC_W-1:0] L_R1CHK = 7'd17;
  localparam logic [PC_W-1:0] L_R2CHK = 7'd36;
  localparam logic [PC_W-1:0] L_R3    = 7'd64;
  localparam logic [PC_W-1:0] L_FIN   = 7'd78;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic uop_t u_alu(input op_t op, input reg_id_t d, input reg_id_t a,
                                 input reg_id_t b);
    uop_t u;
    u = '{op: op, dst: d, a: a, b: b, sh: SH_0, clamp: 1'b0, cond: C_ALWAYS,
          target: '0};
    return u;
  endfunction

  function automatic uop_t u_mul(input reg_id_t d, input reg_id_t a, input reg_id_t b,
                                 input sh_t sh, input logic clamp);
    uop_t u;
    u = '{op: OP_MUL, dst: d, a: a, b: b, sh: sh, clamp: clamp, cond: C_ALWAYS,
          target: '0};
    return u;
  endfunction

  function automatic uop_t u_br(input cond_t c, input reg_id_t a,
                                input logic [PC_W-1:0] t);
    uop_t u;
    u = '{op: OP_BR, dst: R_ZERO, a: a, b: R_ZERO, sh: SH_0, clamp: 1'b0, cond: c,
          target: t};
    return u;
  endfunction

  // microprogram: scale errors, boundaries, region formula, integrate, output
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = u_mul(R_S1, R_E1, R_KP, SH_F, 1'b1);
      7'd1:  u = u_mul(R_S2, R_E2, R_KD, SH_F, 1'b1);
      7'd2:  u = u_alu(OP_SUB, R_B, R_ONE, R_A);
      7'd3:  u = u_br(C_POS, R_S1, L_POS);
      7'd4:  u = u_mul(R_T0, R_A, R_S1, SH_24, 1'b0);
      7'd5:  u = u_alu(OP_SUB, R_N12, R_ZERO, R_T0);
      7'd6:  u = u_mul(R_T1, R_S1, R_B, SH_24, 1'b0);
      7'd7:  u = u_alu(OP_ADD, R_D12, R_ONE, R_T1);
      7'd8:  u = u_alu(OP_SUB, R_N23, R_ZERO, R_S1);
      7'd9:  u = u_alu(OP_SUB, R_D23, R_A, R_T1);
      7'd10: u = u_br(C_ALWAYS, R_ZERO, L_R1CHK);
      7'd11: u = u_alu(OP_SUB, R_N12, R_ZERO, R_S1);
      7'd12: u = u_mul(R_T1, R_S1, R_B, SH_24, 1'b0);
      7'd13: u = u_alu(OP_ADD, R_D12, R_T1, R_A);
      7'd14: u = u_mul(R_T0, R_A, R_S1, SH_24, 1'b0);
      7'd15: u = u_alu(OP_SUB, R_N23, R_ZERO, R_T0);
      7'd16: u = u_alu(OP_SUB, R_D23, R_ONE, R_T1);
      7'd17: u = u_mul(R_T0, R_S2, R_D12, SH_0, 1'b0);
      7'd18: u = u_mul(R_T1, R_N12, R_ONE, SH_0, 1'b0);
      7'd19: u = u_alu(OP_SUB, R_T0, R_T0, R_T1);
      7'd20: u = u_alu(OP_BELOW, R_ZERO, R_T0, R_D12);
      7'd21: u = u_br(C_NFLAG, R_ZERO, L_R2CHK);
      7'd22: u = u_alu(OP_ADD, R_T0, R_ONE, R_S1);
      7'd23: u = u_alu(OP_ADD, R_T1, R_ONE, R_S2);
      7'd24: u = u_mul(R_T2, R_T0, R_T1, SH_24, 1'b0);
      7'd25: u = u_alu(OP_SUB, R_T3, R_T2, R_ONE);
      7'd26: u = u_mul(R_T4, R_A, R_T3, SH_24, 1'b0);
      7'd27: u = u_alu(OP_SUB, R_T5, R_T2, R_T4);
      7'd28: u = u_alu(OP_ADD, R_T5, R_T5, R_T5);
      7'd29: u = u_alu(OP_DIV, R_T6, R_T4, R_T5);
      7'd30: u = u_mul(R_T7, R_A, R_T2, SH_24, 1'b0);
      7'd31: u = u_alu(OP_SUB, R_T7, R_T7, R_T3);
      7'd32: u = u_alu(OP_ADD, R_T7, R_T7, R_T7);
      7'd33: u = u_alu(OP_DIV, R_T7, R_T3, R_T7);
      7'd34: u = u_alu(OP_ADD, R_PHI, R_T6, R_T7);
      7'd35: u = u_br(C_ALWAYS, R_ZERO, L_FIN);
      7'd36: u = u_mul(R_T0, R_S2, R_D23, SH_0, 1'b0);
      7'd37: u = u_mul(R_T1, R_N23, R_ONE, SH_0, 1'b0);
      7'd38: u = u_alu(OP_SUB, R_T0, R_T0, R_T1);
      7'd39: u = u_alu(OP_BELOW, R_ZERO, R_T0, R_D23);
      7'd40: u = u_br(C_NFLAG, R_ZERO, L_R3);
      7'd41: u = u_alu(OP_ADD, R_T0, R_S2, R_ONE);
      7'd42: u = u_mul(R_T1, R_S1, R_T0, SH_24, 1'b0);
      7'd43: u = u_alu(OP_SUB, R_T0, R_S1, R_ONE);
      7'd44: u = u_mul(R_T2, R_S2, R_T0, SH_24, 1'b0);
      7'd45: u = u_mul(R_T3, R_S1, R_S2, SH_24, 1'b0);
      7'd46: u = u_mul(R_T4, R_A, R_T2, SH_24, 1'b0);
      7'd47: u = u_alu(OP_SUB, R_T4, R_T1, R_T4);
      7'd48: u = u_alu(OP_SUB, R_T5, R_ONE, R_S1);
      7'd49: u = u_alu(OP_SUB, R_T5, R_T5, R_T3);
      7'd50: u = u_mul(R_T5, R_A, R_T5, SH_24, 1'b0);
      7'd51: u = u_alu(OP_ADD, R_T5, R_T1, R_T5);
      7'd52: u = u_alu(OP_ADD, R_T5, R_T5, R_T5);
      7'd53: u = u_alu(OP_DIV, R_T6, R_T4, R_T5);
      7'd54: u = u_mul(R_T4, R_A, R_T1, SH_24, 1'b0);
      7'd55: u = u_alu(OP_SUB, R_T4, R_T2, R_T4);
      7'd56: u = u_alu(OP_ADD, R_T5, R_ONE, R_S2);
      7'd57: u = u_alu(OP_SUB, R_T5, R_T5, R_T3);
      7'd58: u = u_mul(R_T5, R_A, R_T5, SH_24, 1'b0);
      7'd59: u = u_alu(OP_ADD, R_T5, R_T2, R_T5);
      7'd60: u = u_alu(OP_ADD, R_T5, R_T5, R_T5);
      7'd61: u = u_alu(OP_DIV, R_T7, R_T4, R_T5);
      7'd62: u = u_alu(OP_SUB, R_PHI, R_T6, R_T7);
      7'd63: u = u_br(C_ALWAYS, R_ZERO, L_FIN);
      7'd64: u = u_alu(OP_SUB, R_T0, R_ONE, R_S1);
      7'd65: u = u_alu(OP_SUB, R_T1, R_ONE, R_S2);
      7'd66: u = u_mul(R_T2, R_T0, R_T1, SH_24, 1'b0);
      7'd67: u = u_alu(OP_SUB, R_T3, R_T2, R_ONE);
      7'd68: u = u_mul(R_T4, R_A, R_T3, SH_24, 1'b0);
      7'd69: u = u_alu(OP_SUB, R_T5, R_T2, R_T4);
      7'd70: u = u_alu(OP_ADD, R_T5, R_T5, R_T5);
      7'd71: u = u_alu(OP_DIV, R_T6, R_T4, R_T5);
      7'd72: u = u_mul(R_T7, R_A, R_T2, SH_24, 1'b0);
      7'd73: u = u_alu(OP_SUB, R_T7, R_T7, R_T3);
      7'd74: u = u_alu(OP_ADD, R_T7, R_T7, R_T7);
      7'd75: u = u_alu(OP_DIV, R_T7, R_T3, R_T7);
      7'd76: u = u_alu(OP_ADD, R_T6, R_T6, R_T7);
      7'd77: u = u_alu(OP_SUB, R_PHI, R_ZERO, R_T6);
      7'd78: u = u_alu(OP_CLIP, R_PHI, R_PHI, R_ZERO);
      7'd79: u = u_mul(R_T0, R_PHI, R_DT, SH_48F, 1'b0);
      7'd80: u = u_alu(OP_ACC, R_INTEG, R_INTEG, R_T0);
      7'd81: u = u_mul(R_T1, R_PHI, R_KPO, SH_48F, 1'b0);
      7'd82: u = u_mul(R_T2, R_INTEG, R_KIO, SH_24, 1'b0);
      7'd83: u = u_alu(OP_ADD, R_T3, R_T1, R_T2);
      7'd84: u = u_mul(R_T4, R_PHI, R_UNIT, SH_24F, 1'b0);
      default: u = u_alu(OP_DONE, R_ZERO, R_T3, R_T4);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/it2fpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// it2fpi_ctrl
// Sequencer: accepts one word, steps the microprogram, waits on the datapath.
// ----------------------------------------------------------------------------
module it2fpi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output it2fpi_pkg::dp_cmd_t cmd,
  input  it2fpi_pkg::dp_stat_t st
);
  import it2fpi_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  uop_t            u;

  assign u        = ucode(pc);
  assign in_stall = (state != S_IDLE);
  assign cmd      = '{load: (state == S_IDLE) && in_valid, run: (state == S_RUN), uop: u};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (st.done) begin
            if (u.op == OP_DONE) state <= S_IDLE;
            else if (st.take) pc <= u.target;
            else pc <= pc + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/it2fpi_dp.sv =====
// ----------------------------------------------------------------------------
// it2fpi_dp
// Datapath: register file, multiplier, radix-2 divider, integrators
// and the output register.
// ----------------------------------------------------------------------------
module it2fpi_dp #(
  parameter int AXES      = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  it2fpi_pkg::dp_cmd_t  cmd,
  output it2fpi_pkg::dp_stat_t st,
  input  logic [31:0]          prop_input_gain,
  input  logic [31:0]          deriv_input_gain,
  input  logic [31:0]          prop_output_gain,
  input  logic [31:0]          integral_output_gain,
  input  logic [15:0]          lower_height_first,
  input  logic [15:0]          lower_height_second,
  input  logic [24:0]          step_time,
  input  logic [1:0]           axis,
  input  logic signed [31:0]   desired_position,
  input  logic signed [31:0]   actual_position,
  input  logic signed [31:0]   desired_velocity,
  input  logic signed [31:0]   actual_velocity,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           axis_out,
  output logic signed [31:0]   command
);
  import it2fpi_pkg::*;

  localparam int IDX_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DIV_STEPS = 64;
  localparam logic signed [33:0] PI_F =
    34'((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [34:0] TWO_PI = 35'(PI_F) <<< 1;

  logic signed [63:0] rf [32];
  logic signed [31:0] integ [AXES];
  logic [1:0]         axis_r;
  logic               flag;
  logic [6:0]         ph;
  logic [127:0]       acc;
  logic [63:0]        dvd;
  logic [64:0]        rem;

  uop_t               u;
  logic signed [63:0] a_val, b_val;
  logic [63:0]        mag_a, mag_b;
  logic               neg;
  logic [6:0]         shv;
  logic [31:0]        ha, hb;
  logic [63:0]        pp;
  logic [127:0]       pp_sh, half, rnd;
  logic [63:0]        mres_mag;
  logic signed [63:0] mres;
  logic [64:0]        rem_s;
  logic               ge;
  logic               ax_ok;
  logic [IDX_W-1:0]   ax_idx, axr_idx;
  logic signed [33:0] diff;
  logic signed [34:0] e1_w;
  logic [15:0]        a1, a2;
  logic signed [63:0] acc_sum;

  function automatic logic signed [63:0] rd(input reg_id_t id);
    logic signed [63:0] v;
    case (id)
      R_ZERO:  v = '0;
      R_ONE:   v = ONE24;
      R_UNIT:  v = 64'sd1;
      R_KP:    v = {32'd0, prop_input_gain};
      R_KD:    v = {32'd0, deriv_input_gain};
      R_KPO:   v = {32'd0, prop_output_gain};
      R_KIO:   v = {32'd0, integral_output_gain};
      R_DT:    v = {39'd0, step_time};
      default: v = rf[id];
    endcase
    return v;
  endfunction

  assign u     = cmd.uop;
  always_comb begin
    a_val = rd(u.a);
    b_val = rd(u.b);
  end
  assign mag_a = a_val[63] ? 64'(-a_val) : 64'(a_val);
  assign mag_b = b_val[63] ? 64'(-b_val) : 64'(b_val);
  assign neg   = a_val[63] ^ b_val[63];

  always_comb begin
    case (u.sh)
      SH_24:   shv = 7'd24;
      SH_F:    shv = 7'(FRAC_BITS);
      SH_48F:  shv = 7'(48 - FRAC_BITS);
      SH_24F:  shv = 7'(24 - FRAC_BITS);
      default: shv = 7'd0;
    endcase
  end

  // one 32x32 partial product per cycle
  assign ha    = ph[1] ? mag_a[63:32] : mag_a[31:0];
  assign hb    = ph[0] ? mag_b[63:32] : mag_b[31:0];
  assign pp    = 64'(ha) * 64'(hb);
  assign pp_sh = (ph[1] & ph[0]) ? {pp, 64'd0} :
                 (ph[1] | ph[0]) ? {32'd0, pp, 32'd0} : {64'd0, pp};
  assign half  = (shv == 7'd0) ? 128'd0 : (128'd1 << (shv - 7'd1));
  assign rnd   = (acc + half) >> shv;
  assign mres_mag = (u.clamp && (rnd > {64'd0, ONE24})) ? 64'(ONE24) : rnd[63:0];
  assign mres  = neg ? -$signed(mres_mag) : $signed(mres_mag);

  assign rem_s = {rem[63:0], dvd[63]};
  assign ge    = rem_s >= {1'b0, mag_b};

  assign ax_ok   = int'(axis_r) < AXES;
  assign axr_idx = IDX_W'(axis_r);
  assign ax_idx  = IDX_W'(axis);
  assign acc_sum = 64'(sat32(a_val + b_val));

  // yaw wrap: move the actual angle by 2*pi toward the desired one
  assign diff = 34'(desired_position) - 34'(actual_position);
  always_comb begin
    e1_w = 35'(diff);
    if ((axis == YAW_AXIS) && ((diff > PI_F) || (diff < -PI_F))) begin
      if (desired_position < actual_position) e1_w = 35'(diff) + TWO_PI;
      else e1_w = 35'(diff) - TWO_PI;
    end
  end

  assign a1 = (lower_height_first > 16'd32768) ? 16'd32768 : lower_height_first;
  assign a2 = (lower_height_second > 16'd32768) ? 16'd32768 : lower_height_second;

  always_comb begin
    st.take = 1'b0;
    case (u.op)
      OP_MUL:  st.done = (ph == 7'd4);
      OP_DIV:  st.done = ((ph == 7'd0) && (mag_b == 64'd0)) || (ph == 7'(DIV_STEPS + 1));
      OP_DONE: st.done = !out_valid || !out_stall;
      OP_BR: begin
        st.done = 1'b1;
        case (u.cond)
          C_POS:   st.take = a_val > 64'sd0;
          C_NFLAG: st.take = !flag;
          default: st.take = 1'b1;
        endcase
      end
      default: st.done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < AXES; i++) integ[i] <= '0;
    end else begin
      if (out_valid && !out_stall && !(cmd.run && (u.op == OP_DONE))) out_valid <= 1'b0;
      if (cmd.load) begin
        axis_r     <= axis;
        rf[R_E1]   <= 64'(e1_w);
        rf[R_E2]   <= 64'(35'(desired_velocity) - 35'(actual_velocity));
        rf[R_A]    <= 64'((32'(a1) * 32'(a2) + 32'd32) >> 6);
        rf[R_INTEG] <= (int'(axis) < AXES) ? 64'(integ[ax_idx]) : 64'sd0;
      end
      if (cmd.run) begin
        case (u.op)
          OP_ADD:  rf[u.dst] <= a_val + b_val;
          OP_SUB:  rf[u.dst] <= a_val - b_val;
          OP_CLIP: begin
            if (a_val > ONE24) rf[u.dst] <= ONE24;
            else if (a_val < -ONE24) rf[u.dst] <= -ONE24;
            else rf[u.dst] <= a_val;
          end
          OP_BELOW: flag <= (b_val != 64'sd0) &&
                            ((b_val > 64'sd0) ? (a_val <= 64'sd0) : (a_val >= 64'sd0));
          OP_MUL: begin
            if (ph == 7'd4) begin
              rf[u.dst] <= mres;
              ph        <= '0;
            end else begin
              acc <= (ph == 7'd0) ? pp_sh : acc + pp_sh;
              ph  <= ph + 7'd1;
            end
          end
          OP_DIV: begin
            if (ph == 7'd0) begin
              if (mag_b == 64'd0) begin
                rf[u.dst] <= '0;
              end else begin
                dvd <= (mag_a << 24) + (mag_b >> 1);
                rem <= '0;
                ph  <= 7'd1;
              end
            end else if (ph == 7'(DIV_STEPS + 1)) begin
              rf[u.dst] <= neg ? -$signed(dvd) : $signed(dvd);
              ph        <= '0;
            end else begin
              rem <= ge ? rem_s - {1'b0, mag_b} : rem_s;
              dvd <= {dvd[62:0], ge};
              ph  <= ph + 7'd1;
            end
          end
          OP_ACC: begin
            if (ax_ok) begin
              rf[u.dst]       <= acc_sum;
              integ[axr_idx]  <= acc_sum[31:0];
            end else begin
              rf[u.dst] <= '0;
            end
          end
          OP_DONE: begin
            if (!out_valid || !out_stall) begin
              out_valid <= 1'b1;
              axis_out  <= axis_r;
              command   <= sat32((axis_r == YAW_AXIS) ? b_val : a_val);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/interval_type2_fuzzy_pi_axis_core.sv =====
// ----------------------------------------------------------------------------
// interval_type2_fuzzy_pi_axis_core
// Interval type-2 fuzzy PI velocity controller, one axis sample per word.
// ----------------------------------------------------------------------------
// Each input word carries the desired and actual position and velocity of one
// axis; each yields exactly one output word with the axis and a saturated
// Q16.16 velocity command. Yaw errors are wrapped by 2*pi, errors are scaled
// and clamped to [-1,1], one of three fuzzy regions is chosen and its rational
// formula evaluated, phi*dt is added to that axis's integrator, and the command
// is k_a*phi + k_b*integral (yaw: phi alone). The microprogram issues 13 to 19
// multiplies on a 32x32 partial-product multiplier and two divides on a
// radix-2 divider (a zero divisor yields zero without the radix-2 steps),
// plus adds and branches; the middle region is the longest path. A
// result that waits on a stalled output adds its stall cycles.
// One word is worked on at a time; the output register lets the next word be
// accepted in the cycle after a result is registered, even while it still waits.
// Configuration writes take effect at once and must only be made while the
// core is idle.
module interval_type2_fuzzy_pi_axis_core #(
  parameter int AXES      = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         axis,
  input  logic signed [31:0] desired_position,
  input  logic signed [31:0] actual_position,
  input  logic signed [31:0] desired_velocity,
  input  logic signed [31:0] actual_velocity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         axis_out,
  output logic signed [31:0] command
);
  import it2fpi_pkg::*;

  logic [31:0] prop_input_gain, deriv_input_gain, prop_output_gain, integral_output_gain;
  logic [15:0] lower_height_first, lower_height_second;
  logic [24:0] step_time;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_input_gain      <= 32'd16777216;
      deriv_input_gain     <= 32'd67109;
      prop_output_gain     <= 32'd1291845;
      integral_output_gain <= 32'd123077657;
      lower_height_first   <= 16'd16384;
      lower_height_second  <= 16'd16384;
      step_time            <= 25'd167772;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_INPUT_GAIN:      prop_input_gain      <= cfg_data;
        REG_DERIV_INPUT_GAIN:     deriv_input_gain     <= cfg_data;
        REG_PROP_OUTPUT_GAIN:     prop_output_gain     <= cfg_data;
        REG_INTEGRAL_OUTPUT_GAIN: integral_output_gain <= cfg_data;
        REG_LOWER_HEIGHT_FIRST:   lower_height_first   <= cfg_data[15:0];
        REG_LOWER_HEIGHT_SECOND:  lower_height_second  <= cfg_data[15:0];
        REG_STEP_TIME:            step_time            <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // sequencer: holds the program counter and the handshake on the input side
  it2fpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  // arithmetic, integrators and output register
  it2fpi_dp #(
    .AXES      (AXES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .st                   (st),
    .prop_input_gain      (prop_input_gain),
    .deriv_input_gain     (deriv_input_gain),
    .prop_output_gain     (prop_output_gain),
    .integral_output_gain (integral_output_gain),
    .lower_height_first   (lower_height_first),
    .lower_height_second  (lower_height_second),
    .step_time            (step_time),
    .axis                 (axis),
    .desired_position     (desired_position),
    .actual_position      (actual_position),
    .desired_velocity     (desired_velocity),
    .actual_velocity      (actual_velocity),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .axis_out             (axis_out),
    .command              (command)
  );

  // an accepted word keeps the core busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("core not busy after accepting a word");

  // a fresh result only comes out of a word in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in progress");

  // the datapath only runs while the sequencer holds the input stalled
  a_run_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> in_stall && !cmd.load)
    else $error("datapath running while core idle");

endmodule

// ===== sim/interval_type2_fuzzy_pi_axis_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_type2_fuzzy_pi_axis_core_test
// Self-checking bench for the interval type-2 fuzzy PI axis core: a short
// directed table, then phases of random axis samples under changing register
// settings, every result compared with a cycle-free fixed-point predictor or a typed value.
// ----------------------------------------------------------------------------
module interval_type2_fuzzy_pi_axis_core_test;
  import it2fpi_pkg::*;

  localparam int  WATCHDOG_LIMIT = 5000;
  localparam int  PHASES         = 8;
  localparam int  PHASE_WORDS    = 236;
  localparam int  REPORT_MAX     = 10;
  localparam longint unsigned U24 = 64'd16777216;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         axis = '0;
  logic signed [31:0] desired_position = '0;
  logic signed [31:0] actual_position = '0;
  logic signed [31:0] desired_velocity = '0;
  logic signed [31:0] actual_velocity = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [1:0]         axis_out;
  logic signed [31:0] command;

  interval_type2_fuzzy_pi_axis_core dut (.*);

  always #1 clk = ~clk;

  // one pending command per accepted sample
  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] command;
  } cmd_word_t;

  cmd_word_t pending_cmds[$];

  // predictor copy of the registers and the per-axis integrators
  longint unsigned kp_in, kd_in, kp_out, ki_out, height1, height2, dt_step;
  longint          integrator[4];

  int  mismatches = 0;
  int  words_sent = 0;
  int  words_got  = 0;
  int  idle_count = 0;
  bit  no_idle    = 1'b0;   // suppress gaps and stalls in some phases
  bit  stim_done  = 1'b0;

  // ---------------------------------------------------------------------------
  // fixed-point helpers, all rounding half away from zero
  // ---------------------------------------------------------------------------
  function automatic longint rnd_scale(longint v, longint unsigned g, int sh);
    longint unsigned m, p;
    m = (v < 0) ? -v : v;
    p = m * g;
    if (sh > 0) p = (p + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint fmul(longint x, longint y);
    longint r;
    r = rnd_scale(x, (y < 0) ? -y : y, 24);
    return (y < 0) ? -r : r;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint unsigned mn, md, q;
    if (d == 0) return 0;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (mn * U24 + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // scaled error clamped to [-1,1] with 24 fraction bits
  function automatic longint sigma_of(longint e, longint unsigned k);
    longint unsigned mag, lim, p;
    mag = (e < 0) ? -e : e;
    if (k == 0 || mag == 0) return 0;
    lim = ((64'd1 << 40) + k - 1) / k;
    if (mag >= lim) p = U24;
    else p = (mag * k + 64'd32768) >> 16;
    return (e < 0) ? -longint'(p) : longint'(p);
  endfunction

  // s2 <= num/den without division; a zero denominator never matches
  function automatic bit under_curve(longint s2, longint num, longint den);
    longint one;
    one = ONE24;
    if (den == 0) return 1'b0;
    if (den > 0) return s2 * den <= num * one;
    return s2 * den >= num * one;
  endfunction

  function automatic longint fuzzy_phi(longint s1, longint s2, longint a);
    longint one, b, n12, d12, n23, d23, phi, p, q, aq, u, w, ss, na, da, nb, db;
    longint m, r, ar;
    one = ONE24;
    b = one - a;
    if (s1 <= 0) begin
      n12 = -fmul(a, s1); d12 = one + fmul(s1, b);
      n23 = -s1;          d23 = a - fmul(s1, b);
    end else begin
      n12 = -s1;          d12 = fmul(s1, b) + a;
      n23 = -fmul(a, s1); d23 = one - fmul(s1, b);
    end
    if (under_curve(s2, n12, d12)) begin
      p = fmul(one + s1, one + s2); q = p - one; aq = fmul(a, q);
      phi = fdiv(aq, 2 * (p - aq)) + fdiv(q, 2 * (fmul(a, p) - q));
    end else if (under_curve(s2, n23, d23)) begin
      u = fmul(s1, s2 + one); w = fmul(s2, s1 - one); ss = fmul(s1, s2);
      na = u - fmul(a, w); da = u + fmul(a, one - s1 - ss);
      nb = w - fmul(a, u); db = w + fmul(a, one + s2 - ss);
      phi = fdiv(na, 2 * da) - fdiv(nb, 2 * db);
    end else begin
      m = fmul(one - s1, one - s2); r = m - one; ar = fmul(a, r);
      phi = -fdiv(ar, 2 * (m - ar)) - fdiv(r, 2 * (fmul(a, m) - r));
    end
    if (phi > one) phi = one;
    if (phi < -one) phi = -one;
    return phi;
  endfunction

  // advance the predictor by one sample and return its command word
  function automatic cmd_word_t predict_command(logic [1:0] ax, longint pd, longint pa,
                                                longint vd, longint va);
    longint unsigned a1, a2;
    longint pi_f, a, s1, s2, phi, integ, cmd;
    cmd_word_t res;
    pi_f = longint'((PI_Q32 + 64'd32768) >> 16);
    a1 = (height1 > 32768) ? 32768 : height1;
    a2 = (height2 > 32768) ? 32768 : height2;
    a = longint'((a1 * a2 + 32) >> 6);
    if (ax == YAW_AXIS && (pd - pa > pi_f || pd - pa < -pi_f)) begin
      if (pd < pa) pa = pa - 2 * pi_f;
      else pa = pa + 2 * pi_f;
    end
    s1 = sigma_of(pd - pa, kp_in);
    s2 = sigma_of(vd - va, kd_in);
    phi = fuzzy_phi(s1, s2, a);
    integrator[ax] = clip32(integrator[ax] + rnd_scale(phi, dt_step, 32));
    integ = integrator[ax];
    if (ax == YAW_AXIS) cmd = rnd_scale(phi, 1, 8);
    else cmd = rnd_scale(phi, kp_out, 32) + rnd_scale(integ, ki_out, 24);
    res.axis = ax;
    res.command = clip32(cmd);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // register writes: only while the core is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_PROP_INPUT_GAIN:      kp_in   = val;
      REG_DERIV_INPUT_GAIN:     kd_in   = val;
      REG_PROP_OUTPUT_GAIN:     kp_out  = val;
      REG_INTEGRAL_OUTPUT_GAIN: ki_out  = val;
      REG_LOWER_HEIGHT_FIRST:   height1 = val[15:0];
      REG_LOWER_HEIGHT_SECOND:  height2 = val[15:0];
      default:                  dt_step = val[24:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // send one word; typed_cmd replaces the predicted command when use_typed
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] ax, logic [31:0] pd, logic [31:0] pa,
                           logic [31:0] vd, logic [31:0] va,
                           bit use_typed, logic [31:0] typed_cmd);
    int gap;
    cmd_word_t exp_word;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk);
    in_valid         = 1'b1;
    axis             = ax;
    desired_position = pd;
    actual_position  = pa;
    desired_velocity = vd;
    actual_velocity  = va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_word = predict_command(ax, longint'($signed(pd)), longint'($signed(pa)),
                               longint'($signed(vd)), longint'($signed(va)));
    if (use_typed) exp_word.command = typed_cmd;
    pending_cmds.push_back(exp_word);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random sample: mostly errors near the unsaturated band, some raw noise,
  // some yaw angles around the wrap point
  task automatic send_random();
    logic [31:0] pd, pa, vd, va;
    int kind;
    kind = $urandom_range(0, 9);
    pd = $urandom();
    vd = $urandom();
    if (kind < 6) begin
      pa = pd + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      va = vd + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
    end else if (kind < 8) begin
      pa = $urandom();
      va = $urandom();
    end else begin
      pd = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      pa = pd + $signed($urandom_range(0, 1 << 19)) - (1 << 18) +
           (($urandom_range(0, 1) != 0) ? 32'sd205887 : -32'sd205887);
      va = vd + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    send_word(kind >= 8 ? YAW_AXIS : 2'($urandom_range(0, 3)), pd, pa, vd, va,
              1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  ax;
    logic [31:0] pd, pa, vd, va;
    bit          typed;
    logic [31:0] cmd;
  } stim_row_t;

  localparam int ROWS = 15;
  stim_row_t directed[ROWS] = '{
    '{2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0},                // quiet x at reset
    '{YAW_AXIS, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0},            // quiet yaw
    '{2'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 1'b0, 32'h0},  // sigma1 at +1
    '{2'd1, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, 32'h0},  // sigma1 at -1
    '{2'd2, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b0, 32'h0},  // sigma2 at +1
    '{2'd0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'h0},  // sigma2 at -1
    '{2'd0, 32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{2'd1, 32'hFFFF0000, 32'h0, 32'h00300000, 32'h0, 1'b0, 32'h0},
    '{YAW_AXIS, 32'd200000, -32'sd10000, 32'h0, 32'h0, 1'b0, 32'h0}, // wrap down
    '{YAW_AXIS, -32'sd200000, 32'd10000, 32'h0, 32'h0, 1'b0, 32'h0}, // wrap up
    '{YAW_AXIS, 32'd205887, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},       // exactly pi
    '{YAW_AXIS, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0, 1'b0, 32'h0},
    '{2'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b0, 32'h0},
    '{2'd3, 32'h12345678, 32'h12340000, 32'hEDCBA987, 32'h0, 1'b0, 32'h0},
    '{2'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0, 32'h0}
  };

  // register settings per phase; phase 0 keeps the reset values
  logic [31:0] phase_regs[PHASES][7] = '{
    '{32'd16777216, 32'd67109, 32'd1291845, 32'd123077657, 32'd16384, 32'd16384,
      32'd167772},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF,
      32'hFFFFFFFF},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    '{32'd16777216, 32'd16777216, 32'd16777216, 32'd16777216, 32'd32768, 32'd32768,
      32'd16777216},
    '{32'd4194304, 32'd262144, 32'd33554432, 32'd1677722, 32'd0, 32'd32768, 32'd65536},
    '{32'd67108864, 32'd1048576, 32'd838861, 32'd50331648, 32'd24576, 32'd8192,
      32'd167772},
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},   // replaced by random values
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}
  };

  // ---------------------------------------------------------------------------
  // result check: compare each accepted word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_word_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      words_got++;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: axis %0d command %0d", axis_out, command);
      end else begin
        exp_word = pending_cmds.pop_front();
        if (axis_out !== exp_word.axis || command !== exp_word.command) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("word %0d: expected axis %0d command %0d, got axis %0d command %0d",
                     words_got, exp_word.axis, exp_word.command, axis_out, command);
        end
      end
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_write)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: hold stall for a random count, then release for one word
  initial begin
    int hold, seen;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 11);
      out_stall = (hold != 0);
      repeat (hold) @(negedge clk);
      out_stall = 1'b0;
      seen = words_got;
      while (words_got == seen) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r, k;
    kp_in = 16777216; kd_in = 67109; kp_out = 1291845; ki_out = 123077657;
    height1 = 16384; height2 = 16384; dt_step = 167772;
    for (k = 0; k < 4; k++) integrator[k] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < ROWS; r++)
      send_word(directed[r].ax, directed[r].pd, directed[r].pa, directed[r].vd,
                directed[r].va, directed[r].typed, directed[r].cmd);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        // drain before touching registers
        wait_drained();
        repeat (8) @(negedge clk);
        for (k = 0; k < 7; k++)
          write_reg(k[2:0], (ph >= 6) ? $urandom() : phase_regs[ph][k]);
      end
      no_idle = (ph % 3 == 2);
      for (r = 0; r < PHASE_WORDS; r++) begin
        send_random();
        // hold off once per phase until the core has emptied
        if (r == PHASE_WORDS / 2) wait_drained();
      end
    end
    stim_done = 1'b1;

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d samples over %0d register settings, %0d commands checked.",
             words_sent, PHASES, words_got);
    $display("Covered saturated errors, yaw wrap, all axes and gap/stall mixes.");
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
